@@ rtl/core/jet_pkg.sv @@
// Shared types and constants for the Julia escape-time iterator.
package jet_pkg;

  // Width of one multiplier digit handled by a single cell.
  localparam int DIGIT_W = 16;

  // Integer bits of the coordinate format; the rest are fraction bits.
  localparam int INT_BITS = 6;

  localparam int ITER_W = 8;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_C_REAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_C_IMAG = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 2'd2;

  // Reset values, given in the 32-bit Q6.26 format.
  localparam logic signed [31:0] C_REAL_RESET_Q26 = 32'sd33554432;
  localparam logic signed [31:0] C_IMAG_RESET_Q26 = 32'sd20132659;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // Status handed from the post-processing stages to the controller.
  typedef struct packed {
    logic valid;
    logic esc;
  } post_status_t;

endpackage

@@ rtl/core/jet_cell.sv @@
// One multiplier cell: adds one digit's partial products for x*x, y*y and x*y.
module jet_cell #(
  parameter int W = 32,
  parameter int IDX = 0,
  parameter int NCELL = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_x,
  input  logic signed [W-1:0]   in_y,
  input  logic signed [2*W-1:0] in_xx,
  input  logic signed [2*W-1:0] in_yy,
  input  logic signed [2*W-1:0] in_xy,
  output logic                  out_valid,
  output logic signed [W-1:0]   out_x,
  output logic signed [W-1:0]   out_y,
  output logic signed [2*W-1:0] out_xx,
  output logic signed [2*W-1:0] out_yy,
  output logic signed [2*W-1:0] out_xy
);
  import jet_pkg::*;

  localparam int DW = NCELL * DIGIT_W;
  localparam int ACC = 2 * W;
  localparam int SH = IDX * DIGIT_W;
  localparam int PW = W + DIGIT_W + 1;

  logic signed [DW-1:0]      x_ext;
  logic signed [DW-1:0]      y_ext;
  logic [DIGIT_W-1:0]        dx;
  logic [DIGIT_W-1:0]        dy;
  logic signed [DIGIT_W:0]   sdx;
  logic signed [DIGIT_W:0]   sdy;
  logic signed [PW-1:0]      pxx;
  logic signed [PW-1:0]      pyy;
  logic signed [PW-1:0]      pxy;
  logic signed [ACC-1:0]     txx;
  logic signed [ACC-1:0]     tyy;
  logic signed [ACC-1:0]     txy;

  assign x_ext = DW'(in_x);
  assign y_ext = DW'(in_y);
  assign dx = x_ext[SH +: DIGIT_W];
  assign dy = y_ext[SH +: DIGIT_W];

  // Only the most significant digit carries the sign of the operand.
  assign sdx = (IDX == NCELL - 1) ? {dx[DIGIT_W-1], dx} : {1'b0, dx};
  assign sdy = (IDX == NCELL - 1) ? {dy[DIGIT_W-1], dy} : {1'b0, dy};

  assign pxx = PW'(in_x * sdx);
  assign pyy = PW'(in_y * sdy);
  assign pxy = PW'(in_x * sdy);

  assign txx = ACC'(pxx) <<< SH;
  assign tyy = ACC'(pyy) <<< SH;
  assign txy = ACC'(pxy) <<< SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x <= in_x;
    out_y <= in_y;
    out_xx <= in_xx + txx;
    out_yy <= in_yy + tyy;
    out_xy <= in_xy + txy;
  end

endmodule

@@ rtl/core/jet_post.sv @@
// Rescales the full products and forms x*x - y*y, 2xy + c_imag and the escape test.
module jet_post #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [2*W-1:0] in_xx,
  input  logic signed [2*W-1:0] in_yy,
  input  logic signed [2*W-1:0] in_xy,
  input  logic signed [W-1:0]   c_imag,
  output jet_pkg::post_status_t st,
  output logic signed [W-1:0]   x_diff,
  output logic signed [W-1:0]   y_next
);
  import jet_pkg::*;

  localparam int ACC = 2 * W;
  localparam int FRAC = W - INT_BITS;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [ACC-1:0] SMAX_ACC = ACC'(SMAX);
  localparam logic signed [ACC-1:0] SMIN_ACC = ACC'(SMIN);
  localparam logic signed [W-1:0] FOUR = W'(64'd1 << (W - 4));

  function automatic logic signed [W-1:0] sat_acc(input logic signed [ACC-1:0] v);
    if (v > SMAX_ACC) begin
      sat_acc = SMAX;
    end else if (v < SMIN_ACC) begin
      sat_acc = SMIN;
    end else begin
      sat_acc = v[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
    if (s[W] != s[W-1]) begin
      sat_sum = s[W] ? SMIN : SMAX;
    end else begin
      sat_sum = s[W-1:0];
    end
  endfunction

  logic                  v1;
  logic                  st_valid;
  logic                  st_esc;
  logic signed [W-1:0]   xx1;
  logic signed [W-1:0]   yy1;
  logic signed [W-1:0]   xy1;
  logic signed [ACC-1:0] xx_sh;
  logic signed [ACC-1:0] yy_sh;
  logic signed [ACC-1:0] xy_sh;
  logic signed [W:0]     diff_s;
  logic signed [W:0]     mag_s;
  logic signed [W:0]     ny_s;
  logic signed [W-1:0]   mag;

  // An arithmetic shift floors, as the number format requires.
  // The cross term shifts one place less, which doubles it exactly.
  assign xx_sh = in_xx >>> FRAC;
  assign yy_sh = in_yy >>> FRAC;
  assign xy_sh = in_xy >>> (FRAC - 1);

  always_ff @(posedge clk) begin
    xx1 <= sat_acc(xx_sh);
    yy1 <= sat_acc(yy_sh);
    xy1 <= sat_acc(xy_sh);
  end

  assign diff_s = (W+1)'(xx1) - (W+1)'(yy1);
  assign mag_s = (W+1)'(xx1) + (W+1)'(yy1);
  assign ny_s = (W+1)'(xy1) + (W+1)'(c_imag);
  assign mag = sat_sum(mag_s);

  always_ff @(posedge clk) begin
    x_diff <= sat_sum(diff_s);
    y_next <= sat_sum(ny_s);
    st_esc <= (mag > FOUR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      st_valid <= v1;
    end
  end

  assign st.valid = st_valid;
  assign st.esc = st_esc;

endmodule

@@ rtl/core/julia_escape_time_top.sv @@
// Top level of the Julia escape-time iterator: configuration, control and cell row.
//
// Start points arrive on the s_axis channel, one point per beat, and each gives
// exactly one result beat on m_axis: the escape index in tdata and the escaped
// flag in tuser. The constant c and the iteration limit are written through the
// cfg channel, which is always ready; write it only while no point is in work.
// Each pass of z := z*z + c travels once through the loop made of the x/y
// register, a row of NCELL multiplier cells (one 16-bit digit each, NCELL =
// COORD_WIDTH/16 rounded up) and two post-processing stages. A point runs
// max_iterations + 1 passes at most, the last one only for the escape test, and
// its result enters the output register once its passes end, sooner when it
// escapes early. One point is in work at a time; s_axis_tready is high
// whenever the loop is free, even while a result still waits in the output
// register. When the receiver stalls, a finished result is held and the loop
// waits until the output register frees.
// Synchronous reset clears the control state and loads c = 0.5 + 0.3i and a
// limit of 100.
module julia_escape_time_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // Fields from bit 0 up: z_real, z_imag, zero padding.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // Fields from bit 0 up: iter_count.
  output logic [7:0]                                  m_axis_tdata,
  // Fields from bit 0 up: escaped.
  output logic [0:0]                                  m_axis_tuser,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [jet_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0]                      cfg_data
);
  import jet_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int ACC = 2 * W;
  localparam int NCELL = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int UP = (W >= 32) ? W - 32 : 0;
  localparam int DOWN = (W >= 32) ? 0 : 32 - W;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] C_REAL_RST =
    (W >= 32) ? W'(64'(C_REAL_RESET_Q26) <<< UP) : W'(C_REAL_RESET_Q26 >>> DOWN);
  localparam logic signed [W-1:0] C_IMAG_RST =
    (W >= 32) ? W'(64'(C_IMAG_RESET_Q26) <<< UP) : W'(C_IMAG_RESET_Q26 >>> DOWN);

  state_t state;

  logic signed [W-1:0]  c_real;
  logic signed [W-1:0]  c_imag;
  logic [ITER_W-1:0]    max_iterations;

  logic                 go;
  logic signed [W-1:0]  x;
  logic signed [W-1:0]  y;
  logic [ITER_W-1:0]    pass_cnt;
  logic [ITER_W-1:0]    res_cnt;
  logic                 res_esc;

  logic                 cv [NCELL+1];
  logic signed [W-1:0]  cx [NCELL+1];
  logic signed [W-1:0]  cy [NCELL+1];
  logic signed [ACC-1:0] cxx [NCELL+1];
  logic signed [ACC-1:0] cyy [NCELL+1];
  logic signed [ACC-1:0] cxy [NCELL+1];
  logic [NCELL-1:0]     cell_busy;

  post_status_t         st;
  logic signed [W-1:0]  x_diff;
  logic signed [W-1:0]  y_next;
  logic signed [W:0]    nx_s;
  logic signed [W-1:0]  nx;

  logic                 in_beat;
  logic                 out_free;
  logic                 fin_esc;
  logic                 fin_lim;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // The escape test of pass 0 looks at the start point and is not counted.
  assign fin_esc = st.valid && (pass_cnt != '0) && st.esc;
  assign fin_lim = st.valid && !fin_esc && (pass_cnt == max_iterations);

  assign nx_s = (W+1)'(x_diff) + (W+1)'(c_real);
  assign nx = (nx_s[W] != nx_s[W-1]) ? (nx_s[W] ? SMIN : SMAX) : nx_s[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real <= C_REAL_RST;
      c_imag <= C_IMAG_RST;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C_REAL:   c_real <= cfg_data;
        REG_C_IMAG:   c_imag <= cfg_data;
        REG_MAX_ITER: max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go <= 1'b0;
      pass_cnt <= '0;
    end else begin
      go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            go <= 1'b1;
            pass_cnt <= '0;
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (fin_esc || fin_lim) begin
            state <= ST_HOLD;
          end else if (st.valid) begin
            go <= 1'b1;
            pass_cnt <= pass_cnt + 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      x <= s_axis_tdata[W-1:0];
      y <= s_axis_tdata[2*W-1:W];
    end else if (state == ST_BUSY && st.valid) begin
      x <= nx;
      y <= y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_esc) begin
      res_cnt <= pass_cnt - 1'b1;
      res_esc <= 1'b1;
    end else if (fin_lim) begin
      res_cnt <= max_iterations;
      res_esc <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      m_axis_tdata <= res_cnt;
      m_axis_tuser <= res_esc;
    end
  end

  assign cv[0] = go;
  assign cx[0] = x;
  assign cy[0] = y;
  assign cxx[0] = '0;
  assign cyy[0] = '0;
  assign cxy[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    jet_cell #(
      .W(W),
      .IDX(k),
      .NCELL(NCELL)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(cv[k]),
      .in_x(cx[k]),
      .in_y(cy[k]),
      .in_xx(cxx[k]),
      .in_yy(cyy[k]),
      .in_xy(cxy[k]),
      .out_valid(cv[k+1]),
      .out_x(cx[k+1]),
      .out_y(cy[k+1]),
      .out_xx(cxx[k+1]),
      .out_yy(cyy[k+1]),
      .out_xy(cxy[k+1])
    );
    assign cell_busy[k] = cv[k+1];
  end

  jet_post #(
    .W(W)
  ) u_post (
    .clk(clk),
    .rst(rst),
    .in_valid(cv[NCELL]),
    .in_xx(cxx[NCELL]),
    .in_yy(cyy[NCELL]),
    .in_xy(cxy[NCELL]),
    .c_imag(c_imag),
    .st(st),
    .x_diff(x_diff),
    .y_next(y_next)
  );

  // A single pass circulates, so at most one stage of the loop holds it.
  a_one_pass: assert property (@(posedge clk) disable iff (rst)
    $onehot0({go, cell_busy, st.valid}))
    else $error("more than one pass in the loop");

  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |-> state == ST_BUSY)
    else $error("pass launched outside a busy period");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY |-> pass_cnt <= max_iterations)
    else $error("pass count beyond the iteration limit");

  a_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] ? (m_axis_tdata < max_iterations)
                                       : (m_axis_tdata == max_iterations)))
    else $error("result count does not match escaped flag");

endmodule
